[design/sgi_pkg.sv]
package sgi_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CW = 32;
    localparam int DW = 33;
    localparam int PW = 66;
    localparam int MW = 65;
    localparam int QDEPTH = 8;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_POINT,
        CLS_SKEW,
        CLS_COLL
    } t_cls;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_POINT = 2'd1;
    localparam logic [1:0] KIND_SPAN  = 2'd2;

    typedef struct packed {
        logic signed [CW-1:0] p1x;
        logic signed [CW-1:0] p1y;
        logic signed [CW-1:0] p2x;
        logic signed [CW-1:0] p2y;
        logic signed [CW-1:0] q1x;
        logic signed [CW-1:0] q1y;
        logic signed [CW-1:0] q2x;
        logic signed [CW-1:0] q2y;
    } t_pair;

    typedef struct packed {
        t_cls                 cls;
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [MW-1:0]        num0;
        logic [MW-1:0]        num1;
        logic [MW-1:0]        den;
        logic                 neg0;
        logic                 neg1;
    } t_job;

endpackage

[design/sgi_front.sv]
module sgi_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  sgi_pkg::t_pair  i_pair,
    output logic            o_push,
    output sgi_pkg::t_job   o_job
);

    localparam int CW = sgi_pkg::CW;
    localparam int DW = sgi_pkg::DW;
    localparam int PW = sgi_pkg::PW;
    localparam int MW = sgi_pkg::MW;

    function automatic logic [MW-1:0] mag_wide(input logic signed [PW-1:0] x);
        logic [PW-1:0] a;
        a = x[PW-1] ? -x : x;
        return a[MW-1:0];
    endfunction

    function automatic logic [MW-1:0] mag_diff(input logic signed [DW-1:0] x);
        logic [DW-1:0] a;
        a = x[DW-1] ? -x : x;
        return MW'(a);
    endfunction

    function automatic logic between(input logic signed [CW-1:0] a,
                                     input logic signed [CW-1:0] b,
                                     input logic signed [CW-1:0] p);
        return (a <= p && p <= b) || (a >= p && p >= b);
    endfunction

    // stage 1: differences
    logic                 r1_v;
    sgi_pkg::t_pair       r1_pt;
    logic signed [DW-1:0] r1_ux, r1_uy, r1_vx, r1_vy, r1_wx, r1_wy, r1_ex, r1_ey;

    // stage 2: products and point tests
    logic                 r2_v;
    logic signed [PW-1:0] r2_uxvy, r2_uyvx, r2_uxwy, r2_uywx, r2_vxwy, r2_vywx;
    logic                 r2_upt, r2_vpt, r2_same, r2_onq, r2_onp;
    logic signed [CW-1:0] r2_p1x, r2_p1y, r2_q1x, r2_q1y;
    logic signed [DW-1:0] r2_ux, r2_uy, r2_vx, r2_vy, r2_wx, r2_wy, r2_ex, r2_ey;

    // stage 3: cross products
    logic                 r3_v;
    logic signed [PW-1:0] r3_d, r3_puw, r3_pvw;
    logic                 r3_upt, r3_vpt, r3_same, r3_onq, r3_onp;
    logic signed [CW-1:0] r3_p1x, r3_p1y, r3_q1x, r3_q1y;
    logic signed [DW-1:0] r3_ux, r3_uy, r3_vx, r3_vy, r3_wx, r3_wy, r3_ex, r3_ey;

    logic signed [DW-1:0] n_p1x, n_p1y, n_p2x, n_p2y, n_q1x, n_q1y, n_q2x, n_q2y;
    sgi_pkg::t_job        n_job;

    always_comb begin
        n_p1x = i_pair.p1x;
        n_p1y = i_pair.p1y;
        n_p2x = i_pair.p2x;
        n_p2y = i_pair.p2y;
        n_q1x = i_pair.q1x;
        n_q1y = i_pair.q1y;
        n_q2x = i_pair.q2x;
        n_q2y = i_pair.q2y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_pt <= i_pair;
        r1_ux <= n_p2x - n_p1x;
        r1_uy <= n_p2y - n_p1y;
        r1_vx <= n_q2x - n_q1x;
        r1_vy <= n_q2y - n_q1y;
        r1_wx <= n_p1x - n_q1x;
        r1_wy <= n_p1y - n_q1y;
        r1_ex <= n_p2x - n_q1x;
        r1_ey <= n_p2y - n_q1y;

        r2_uxvy <= r1_ux * r1_vy;
        r2_uyvx <= r1_uy * r1_vx;
        r2_uxwy <= r1_ux * r1_wy;
        r2_uywx <= r1_uy * r1_wx;
        r2_vxwy <= r1_vx * r1_wy;
        r2_vywx <= r1_vy * r1_wx;
        r2_upt  <= (r1_ux == '0) && (r1_uy == '0);
        r2_vpt  <= (r1_vx == '0) && (r1_vy == '0);
        r2_same <= (r1_pt.p1x == r1_pt.q1x) && (r1_pt.p1y == r1_pt.q1y);
        // first start on the second segment, tested on x unless that one is vertical
        r2_onq  <= (r1_pt.q1x != r1_pt.q2x)
                   ? between(r1_pt.q1x, r1_pt.q2x, r1_pt.p1x)
                   : between(r1_pt.q1y, r1_pt.q2y, r1_pt.p1y);
        r2_onp  <= (r1_pt.p1x != r1_pt.p2x)
                   ? between(r1_pt.p1x, r1_pt.p2x, r1_pt.q1x)
                   : between(r1_pt.p1y, r1_pt.p2y, r1_pt.q1y);
        r2_p1x <= r1_pt.p1x;
        r2_p1y <= r1_pt.p1y;
        r2_q1x <= r1_pt.q1x;
        r2_q1y <= r1_pt.q1y;
        r2_ux  <= r1_ux;
        r2_uy  <= r1_uy;
        r2_vx  <= r1_vx;
        r2_vy  <= r1_vy;
        r2_wx  <= r1_wx;
        r2_wy  <= r1_wy;
        r2_ex  <= r1_ex;
        r2_ey  <= r1_ey;

        r3_d    <= r2_uxvy - r2_uyvx;
        r3_puw  <= r2_uxwy - r2_uywx;
        r3_pvw  <= r2_vxwy - r2_vywx;
        r3_upt  <= r2_upt;
        r3_vpt  <= r2_vpt;
        r3_same <= r2_same;
        r3_onq  <= r2_onq;
        r3_onp  <= r2_onp;
        r3_p1x  <= r2_p1x;
        r3_p1y  <= r2_p1y;
        r3_q1x  <= r2_q1x;
        r3_q1y  <= r2_q1y;
        r3_ux   <= r2_ux;
        r3_uy   <= r2_uy;
        r3_vx   <= r2_vx;
        r3_vy   <= r2_vy;
        r3_wx   <= r2_wx;
        r3_wy   <= r2_wy;
        r3_ex   <= r2_ex;
        r3_ey   <= r2_ey;
    end

    always_comb begin
        n_job        = '0;
        n_job.cls    = sgi_pkg::CLS_NONE;
        n_job.base_x = r3_p1x;
        n_job.base_y = r3_p1y;
        n_job.dx     = r3_ux;
        n_job.dy     = r3_uy;
        priority if (r3_d != '0) begin
            n_job.cls  = sgi_pkg::CLS_SKEW;
            n_job.num0 = mag_wide(r3_pvw);
            n_job.num1 = mag_wide(r3_puw);
            n_job.den  = mag_wide(r3_d);
            n_job.neg0 = r3_pvw[PW-1] ^ r3_d[PW-1];
            n_job.neg1 = r3_puw[PW-1] ^ r3_d[PW-1];
        end else if (r3_puw != '0 || r3_pvw != '0) begin
            n_job.cls = sgi_pkg::CLS_NONE;
        end else if (r3_upt && r3_vpt) begin
            n_job.cls = r3_same ? sgi_pkg::CLS_POINT : sgi_pkg::CLS_NONE;
        end else if (r3_upt) begin
            n_job.cls = r3_onq ? sgi_pkg::CLS_POINT : sgi_pkg::CLS_NONE;
        end else if (r3_vpt) begin
            n_job.cls    = r3_onp ? sgi_pkg::CLS_POINT : sgi_pkg::CLS_NONE;
            n_job.base_x = r3_q1x;
            n_job.base_y = r3_q1y;
        end else begin
            n_job.cls    = sgi_pkg::CLS_COLL;
            n_job.base_x = r3_q1x;
            n_job.base_y = r3_q1y;
            n_job.dx     = r3_vx;
            n_job.dy     = r3_vy;
            if (r3_vx != '0) begin
                n_job.num0 = mag_diff(r3_wx);
                n_job.num1 = mag_diff(r3_ex);
                n_job.den  = mag_diff(r3_vx);
                n_job.neg0 = r3_wx[DW-1] ^ r3_vx[DW-1];
                n_job.neg1 = r3_ex[DW-1] ^ r3_vx[DW-1];
            end else begin
                n_job.num0 = mag_diff(r3_wy);
                n_job.num1 = mag_diff(r3_ey);
                n_job.den  = mag_diff(r3_vy);
                n_job.neg0 = r3_wy[DW-1] ^ r3_vy[DW-1];
                n_job.neg1 = r3_ey[DW-1] ^ r3_vy[DW-1];
            end
        end
    end

    assign o_push = r3_v;
    assign o_job  = n_job;

endmodule

[design/sgi_queue.sv]
module sgi_queue #(
    parameter int DEPTH = sgi_pkg::QDEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sgi_pkg::t_job  i_job,
    input  logic           i_pop,
    output logic           o_nonempty,
    output sgi_pkg::t_job  o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    sgi_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CNTW-1:0] r_cnt;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= wrap_inc(r_wp);
            if (i_pop)  r_rp <= wrap_inc(r_rp);
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNTW'(1);
                2'b01:   r_cnt <= r_cnt - CNTW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_nonempty = (r_cnt != '0);
    assign o_job      = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> r_cnt < CNTW'(DEPTH))
        else $error("item pushed into full queue");

endmodule

[design/sgi_div.sv]
module sgi_div #(
    parameter int FB = sgi_pkg::FRACTION_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_ce,
    input  logic [sgi_pkg::MW-1:0] i_num,
    input  logic [sgi_pkg::MW-1:0] i_den,
    output logic [FB:0]            o_q,
    output logic                   o_ovf
);

    localparam int MW = sgi_pkg::MW;
    localparam int NS = FB + 2;

    logic [MW:0]   r_rem [NS];
    logic [MW-1:0] r_den [NS];
    logic [FB:0]   r_q   [NS];
    logic          r_ovf [NS];

    // quotient of num * 2^FB / den, one bit a stage; too large once num reaches 2*den
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ovf[0] <= {1'b0, i_num} >= {i_den, 1'b0};
            r_rem[0] <= ({1'b0, i_num} >= {i_den, 1'b0}) ? '0 : {1'b0, i_num};
            r_den[0] <= i_den;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_step
        logic [MW:0] w_sh;
        logic        w_ge;
        assign w_sh = (k == 1) ? r_rem[k-1] : {r_rem[k-1][MW-1:0], 1'b0};
        assign w_ge = w_sh >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k] <= w_ge ? w_sh - {1'b0, r_den[k-1]} : w_sh;
                r_den[k] <= r_den[k-1];
                r_q[k]   <= {r_q[k-1][FB-1:0], w_ge};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_q   = r_q[NS-1];
    assign o_ovf = r_ovf[NS-1];

endmodule

[design/sgi_back.sv]
module sgi_back #(
    parameter int FB = sgi_pkg::FRACTION_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  sgi_pkg::t_job                 i_job,
    output logic                          o_take,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_kind,
    output logic signed [sgi_pkg::CW-1:0] o_point_a_x,
    output logic signed [sgi_pkg::CW-1:0] o_point_a_y,
    output logic signed [sgi_pkg::CW-1:0] o_point_b_x,
    output logic signed [sgi_pkg::CW-1:0] o_point_b_y
);

    localparam int CW  = sgi_pkg::CW;
    localparam int DW  = sgi_pkg::DW;
    localparam int NS  = FB + 2;
    localparam int QW  = FB + 1;
    localparam int SVW = FB + 3;
    localparam int PRW = DW + QW + 1;
    localparam logic [QW-1:0]         Q_ONE = QW'(1) << FB;
    localparam logic signed [SVW-1:0] S_ONE = SVW'(1) << FB;
    localparam logic signed [SVW-1:0] S_TWO = SVW'(2) << FB;
    localparam logic signed [PRW-1:0] BIAS  = (PRW'(1) << FB) - PRW'(1);
    localparam logic signed [PRW-1:0] S_MAX = PRW'(32'h7fff_ffff);
    localparam logic signed [PRW-1:0] S_MIN = -(PRW'(32'h7fff_ffff)) - PRW'(1);

    typedef struct packed {
        sgi_pkg::t_cls        cls;
        logic signed [CW-1:0] base_x;
        logic signed [CW-1:0] base_y;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic                 neg0;
        logic                 neg1;
    } t_ctx;

    logic ce;
    assign ce     = !o_valid || i_ready;
    assign o_take = ce && i_valid;

    logic [QW-1:0] w_q0, w_q1;
    logic          w_ovf0, w_ovf1;

    sgi_div #(.FB(FB)) u_div0 (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (i_job.num0),
        .i_den (i_job.den),
        .o_q   (w_q0),
        .o_ovf (w_ovf0)
    );

    sgi_div #(.FB(FB)) u_div1 (
        .i_clk (i_clk),
        .i_ce  (ce),
        .i_num (i_job.num1),
        .i_den (i_job.den),
        .o_q   (w_q1),
        .o_ovf (w_ovf1)
    );

    t_ctx r_ctx [NS];
    logic r_cv  [NS];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ctx[0] <= '{cls: i_job.cls, base_x: i_job.base_x, base_y: i_job.base_y,
                          dx: i_job.dx, dy: i_job.dy, neg0: i_job.neg0, neg1: i_job.neg1};
            for (int k = 1; k < NS; k++) r_ctx[k] <= r_ctx[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_cv[k] <= 1'b0;
        end else if (ce) begin
            r_cv[0] <= i_valid;
            for (int k = 1; k < NS; k++) r_cv[k] <= r_cv[k-1];
        end
    end

    // parameter stage
    t_ctx                 w_c;
    logic                 w_ok0, w_ok1;
    logic signed [SVW-1:0] w_sv0, w_sv1, w_lo, w_hi, w_c0, w_c1;
    logic [1:0]           n_kind;
    logic [QW-1:0]        n_pa, n_pb;

    always_comb begin
        w_c   = r_ctx[NS-1];
        w_ok0 = !w_ovf0 && (w_q0 == '0 || (!w_c.neg0 && w_q0 <= Q_ONE));
        w_ok1 = !w_ovf1 && (w_q1 == '0 || (!w_c.neg1 && w_q1 <= Q_ONE));
        // an oversized quotient only has to stay beyond the unit range on its side
        w_sv0 = w_ovf0 ? (w_c.neg0 ? -S_TWO : S_TWO)
                       : (w_c.neg0 ? -$signed({2'b00, w_q0}) : $signed({2'b00, w_q0}));
        w_sv1 = w_ovf1 ? (w_c.neg1 ? -S_TWO : S_TWO)
                       : (w_c.neg1 ? -$signed({2'b00, w_q1}) : $signed({2'b00, w_q1}));
        w_lo  = (w_sv0 > w_sv1) ? w_sv1 : w_sv0;
        w_hi  = (w_sv0 > w_sv1) ? w_sv0 : w_sv1;
        w_c0  = (w_lo < 0) ? '0 : w_lo;
        w_c1  = (w_hi > S_ONE) ? S_ONE : w_hi;
        n_kind = sgi_pkg::KIND_NONE;
        n_pa   = '0;
        n_pb   = '0;
        unique case (w_c.cls)
            sgi_pkg::CLS_NONE: begin
                n_kind = sgi_pkg::KIND_NONE;
            end
            sgi_pkg::CLS_POINT: begin
                n_kind = sgi_pkg::KIND_POINT;
            end
            sgi_pkg::CLS_SKEW: begin
                if (w_ok0 && w_ok1) begin
                    n_kind = sgi_pkg::KIND_POINT;
                    n_pa   = w_q0;
                end
            end
            sgi_pkg::CLS_COLL: begin
                if (!(w_lo > S_ONE || w_hi < 0)) begin
                    n_pa   = w_c0[QW-1:0];
                    n_pb   = w_c1[QW-1:0];
                    n_kind = (w_c0 == w_c1) ? sgi_pkg::KIND_POINT : sgi_pkg::KIND_SPAN;
                end
            end
            default: n_kind = sgi_pkg::KIND_NONE;
        endcase
    end

    logic                 r_p_v, r_m_v, r_s_v, r_o_v;
    logic [1:0]           r_p_kind, r_m_kind, r_s_kind, r_o_kind;
    logic [QW-1:0]        r_p_pa, r_p_pb;
    logic signed [CW-1:0] r_p_bx, r_p_by, r_m_bx, r_m_by;
    logic signed [DW-1:0] r_p_dx, r_p_dy;
    logic signed [PRW-1:0] r_m_ax, r_m_ay, r_m_bxp, r_m_byp;
    logic signed [PRW-1:0] r_s_ax, r_s_ay, r_s_bx, r_s_by;
    logic signed [CW-1:0] r_o_ax, r_o_ay, r_o_bx, r_o_by;

    function automatic logic signed [PRW-1:0] place(input logic signed [CW-1:0] base,
                                                    input logic signed [PRW-1:0] p);
        logic signed [PRW-1:0] b;
        logic signed [PRW-1:0] t;
        b = base;
        // truncate toward zero
        t = (p < 0) ? ((p + BIAS) >>> FB) : (p >>> FB);
        return b + t;
    endfunction

    function automatic logic signed [CW-1:0] sat(input logic signed [PRW-1:0] v);
        logic signed [PRW-1:0] c;
        c = (v > S_MAX) ? S_MAX : ((v < S_MIN) ? S_MIN : v);
        return c[CW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
            r_m_v <= 1'b0;
            r_s_v <= 1'b0;
            r_o_v <= 1'b0;
        end else if (ce) begin
            r_p_v <= r_cv[NS-1];
            r_m_v <= r_p_v;
            r_s_v <= r_m_v;
            r_o_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_p_kind <= n_kind;
            r_p_pa   <= n_pa;
            r_p_pb   <= n_pb;
            r_p_bx   <= w_c.base_x;
            r_p_by   <= w_c.base_y;
            r_p_dx   <= w_c.dx;
            r_p_dy   <= w_c.dy;

            r_m_kind <= r_p_kind;
            r_m_bx   <= r_p_bx;
            r_m_by   <= r_p_by;
            r_m_ax   <= r_p_dx * $signed({1'b0, r_p_pa});
            r_m_ay   <= r_p_dy * $signed({1'b0, r_p_pa});
            r_m_bxp  <= r_p_dx * $signed({1'b0, r_p_pb});
            r_m_byp  <= r_p_dy * $signed({1'b0, r_p_pb});

            r_s_kind <= r_m_kind;
            r_s_ax   <= place(r_m_bx, r_m_ax);
            r_s_ay   <= place(r_m_by, r_m_ay);
            r_s_bx   <= place(r_m_bx, r_m_bxp);
            r_s_by   <= place(r_m_by, r_m_byp);

            r_o_kind <= r_s_kind;
            r_o_ax   <= (r_s_kind == sgi_pkg::KIND_NONE) ? '0 : sat(r_s_ax);
            r_o_ay   <= (r_s_kind == sgi_pkg::KIND_NONE) ? '0 : sat(r_s_ay);
            r_o_bx   <= (r_s_kind == sgi_pkg::KIND_SPAN) ? sat(r_s_bx) : '0;
            r_o_by   <= (r_s_kind == sgi_pkg::KIND_SPAN) ? sat(r_s_by) : '0;
        end
    end

    assign o_valid     = r_o_v;
    assign o_kind      = r_o_kind;
    assign o_point_a_x = r_o_ax;
    assign o_point_a_y = r_o_ay;
    assign o_point_b_x = r_o_bx;
    assign o_point_b_y = r_o_by;

    a_b_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != sgi_pkg::KIND_SPAN |-> o_point_b_x == '0 && o_point_b_y == '0)
        else $error("overlap end set on a result without overlap");

    a_a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == sgi_pkg::KIND_NONE |-> o_point_a_x == '0 && o_point_a_y == '0)
        else $error("point set on a disjoint result");

endmodule

[design/segment_intersection_2d.sv]
// an accepted item passes through the front stages, the queue, the quotient lanes and the back stages
// throughput: one item per cycle unless stalled; quotient lanes resolve one bit a stage
// the front keeps at most QUEUE_DEPTH items between acceptance and the back pipeline
// reset (synchronous, active low) clears valid bits, queue pointers and the item count
// no clearing pass: the block accepts items in the first cycle after reset
module segment_intersection_2d #(
    parameter int FRACTION_BITS = sgi_pkg::FRACTION_BITS,
    parameter int QUEUE_DEPTH   = sgi_pkg::QDEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [sgi_pkg::CW-1:0] i_first_start_x,
    input  logic signed [sgi_pkg::CW-1:0] i_first_start_y,
    input  logic signed [sgi_pkg::CW-1:0] i_first_end_x,
    input  logic signed [sgi_pkg::CW-1:0] i_first_end_y,
    input  logic signed [sgi_pkg::CW-1:0] i_second_start_x,
    input  logic signed [sgi_pkg::CW-1:0] i_second_start_y,
    input  logic signed [sgi_pkg::CW-1:0] i_second_end_x,
    input  logic signed [sgi_pkg::CW-1:0] i_second_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_kind,
    output logic signed [sgi_pkg::CW-1:0] o_point_a_x,
    output logic signed [sgi_pkg::CW-1:0] o_point_a_y,
    output logic signed [sgi_pkg::CW-1:0] o_point_b_x,
    output logic signed [sgi_pkg::CW-1:0] o_point_b_y
);

    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    sgi_pkg::t_pair  w_pair;
    sgi_pkg::t_job   w_push_job, w_head_job;
    logic            w_accept, w_push, w_nonempty, w_take;
    logic [CNTW-1:0] r_cnt;

    assign w_pair = '{p1x: i_first_start_x,  p1y: i_first_start_y,
                      p2x: i_first_end_x,    p2y: i_first_end_y,
                      q1x: i_second_start_x, q1y: i_second_start_y,
                      q2x: i_second_end_x,   q2y: i_second_end_y};

    // items in the front stages or the queue; the queue never overflows
    assign o_ready  = r_cnt < CNTW'(QUEUE_DEPTH);
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            unique case ({w_accept, w_take})
                2'b10:   r_cnt <= r_cnt + CNTW'(1);
                2'b01:   r_cnt <= r_cnt - CNTW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    sgi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_pair   (w_pair),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    sgi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_job      (w_push_job),
        .i_pop      (w_take),
        .o_nonempty (w_nonempty),
        .o_job      (w_head_job)
    );

    sgi_back #(.FB(FRACTION_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_nonempty),
        .i_job       (w_head_job),
        .o_take      (w_take),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_point_a_x (o_point_a_x),
        .o_point_a_y (o_point_a_y),
        .o_point_b_x (o_point_b_x),
        .o_point_b_y (o_point_b_y)
    );

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(QUEUE_DEPTH))
        else $error("item count beyond queue depth");

    a_take_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> r_cnt != '0)
        else $error("item taken that was never counted");

endmodule

[dv/segment_intersection_2d_test.sv]
module segment_intersection_2d_test;

    localparam int FRACTION_BITS = sgi_pkg::FRACTION_BITS;
    localparam int CW = sgi_pkg::CW;
    localparam longint ONE = 64'sd1 << FRACTION_BITS;
    localparam int IDLE_PCT = 38;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = FRACTION_BITS + 20;
    localparam int RANDOM_ITEMS = 1450;

    typedef struct {
        logic [1:0]           kind;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
    } t_answer;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [CW-1:0] i_first_start_x = '0;
    logic signed [CW-1:0] i_first_start_y = '0;
    logic signed [CW-1:0] i_first_end_x = '0;
    logic signed [CW-1:0] i_first_end_y = '0;
    logic signed [CW-1:0] i_second_start_x = '0;
    logic signed [CW-1:0] i_second_start_y = '0;
    logic signed [CW-1:0] i_second_end_x = '0;
    logic signed [CW-1:0] i_second_end_y = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [1:0]           o_kind;
    logic signed [CW-1:0] o_point_a_x;
    logic signed [CW-1:0] o_point_a_y;
    logic signed [CW-1:0] o_point_b_x;
    logic signed [CW-1:0] o_point_b_y;

    t_answer answers_due[$];
    int      error_count = 0;
    int      quiet_cycles = 0;
    bit      calm = 1'b0;

    segment_intersection_2d u_top (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // exact cross product of two difference vectors
    function automatic logic signed [127:0] perp_dot(longint ax, longint ay,
                                                     longint bx, longint by);
        logic signed [127:0] a1, a2, b1, b2;
        a1 = ax; a2 = ay; b1 = bx; b2 = by;
        return a1 * b2 - a2 * b1;
    endfunction

    // truncated num/den as a fraction, rejected when outside [0,1]
    function automatic bit unit_frac(logic signed [127:0] num, logic signed [127:0] den,
                                     output longint q);
        logic [127:0] n, d, quo;
        bit neg;
        neg = num[127] != den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        quo = (n << FRACTION_BITS) / d;
        q = 0;
        if (quo == 0) return 1'b1;
        if (neg || quo > ONE) return 1'b0;
        q = longint'(quo);
        return 1'b1;
    endfunction

    function automatic logic signed [CW-1:0] place(longint base, longint delta, longint param);
        longint pr, m, v;
        pr = delta * param;
        m = (pr < 0 ? -pr : pr) >>> FRACTION_BITS;
        v = base + (pr < 0 ? -m : m);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[CW-1:0];
    endfunction

    function automatic bit between(longint ax, longint ay, longint bx, longint by,
                                   longint px, longint py);
        if (ax != bx)
            return (ax <= px && px <= bx) || (ax >= px && px >= bx);
        return (ay <= py && py <= by) || (ay >= py && py >= by);
    endfunction

    function automatic t_answer predict(sgi_pkg::t_pair p);
        longint ux, uy, vx, vy, wx, wy, t0, t1, s, t, tmp;
        logic signed [127:0] d;
        bit upt, vpt;
        t_answer r;
        r = '{sgi_pkg::KIND_NONE, '0, '0, '0, '0};
        ux = longint'(p.p2x) - p.p1x; uy = longint'(p.p2y) - p.p1y;
        vx = longint'(p.q2x) - p.q1x; vy = longint'(p.q2y) - p.q1y;
        wx = longint'(p.p1x) - p.q1x; wy = longint'(p.p1y) - p.q1y;
        d = perp_dot(ux, uy, vx, vy);
        if (d != 0) begin
            if (!unit_frac(perp_dot(vx, vy, wx, wy), d, s)) return r;
            if (!unit_frac(perp_dot(ux, uy, wx, wy), d, t)) return r;
            r.kind = sgi_pkg::KIND_POINT;
            r.ax = place(p.p1x, ux, s);
            r.ay = place(p.p1y, uy, s);
            return r;
        end
        if (perp_dot(ux, uy, wx, wy) != 0 || perp_dot(vx, vy, wx, wy) != 0) return r;
        upt = ux == 0 && uy == 0;
        vpt = vx == 0 && vy == 0;
        if (upt && vpt) begin
            if (p.p1x != p.q1x || p.p1y != p.q1y) return r;
            r.kind = sgi_pkg::KIND_POINT; r.ax = p.p1x; r.ay = p.p1y;
            return r;
        end
        if (upt) begin
            if (!between(p.q1x, p.q1y, p.q2x, p.q2y, p.p1x, p.p1y)) return r;
            r.kind = sgi_pkg::KIND_POINT; r.ax = p.p1x; r.ay = p.p1y;
            return r;
        end
        if (vpt) begin
            if (!between(p.p1x, p.p1y, p.p2x, p.p2y, p.q1x, p.q1y)) return r;
            r.kind = sgi_pkg::KIND_POINT; r.ax = p.q1x; r.ay = p.q1y;
            return r;
        end
        if (vx != 0) begin
            t0 = (wx * ONE) / vx;
            t1 = ((longint'(p.p2x) - p.q1x) * ONE) / vx;
        end else begin
            t0 = (wy * ONE) / vy;
            t1 = ((longint'(p.p2y) - p.q1y) * ONE) / vy;
        end
        if (t0 > t1) begin
            tmp = t0; t0 = t1; t1 = tmp;
        end
        if (t0 > ONE || t1 < 0) return r;
        if (t0 < 0) t0 = 0;
        if (t1 > ONE) t1 = ONE;
        r.ax = place(p.q1x, vx, t0);
        r.ay = place(p.q1y, vy, t0);
        if (t0 == t1) begin
            r.kind = sgi_pkg::KIND_POINT;
            return r;
        end
        r.kind = sgi_pkg::KIND_SPAN;
        r.bx = place(p.q1x, vx, t1);
        r.by = place(p.q1y, vy, t1);
        return r;
    endfunction

    always @(posedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result kind %0d", $time, o_kind);
                error_count++;
            end else begin
                want = answers_due.pop_front();
                if (o_kind !== want.kind) begin
                    $display("%0t: kind exp %0d got %0d", $time, want.kind, o_kind);
                    error_count++;
                end
                if (o_point_a_x !== want.ax) begin
                    $display("%0t: a_x exp %0d got %0d", $time, want.ax, o_point_a_x);
                    error_count++;
                end
                if (o_point_a_y !== want.ay) begin
                    $display("%0t: a_y exp %0d got %0d", $time, want.ay, o_point_a_y);
                    error_count++;
                end
                if (o_point_b_x !== want.bx) begin
                    $display("%0t: b_x exp %0d got %0d", $time, want.bx, o_point_b_x);
                    error_count++;
                end
                if (o_point_b_y !== want.by) begin
                    $display("%0t: b_y exp %0d got %0d", $time, want.by, o_point_b_y);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_pair(sgi_pkg::t_pair p);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_first_start_x  <= p.p1x;
        i_first_start_y  <= p.p1y;
        i_first_end_x    <= p.p2x;
        i_first_end_y    <= p.p2y;
        i_second_start_x <= p.q1x;
        i_second_start_y <= p.q1y;
        i_second_end_x   <= p.q2x;
        i_second_end_y   <= p.q2y;
        do @(posedge i_clk); while (!o_ready);
        answers_due.push_back(predict(p));
    endtask

    task automatic pair8(longint a, longint b, longint c, longint d,
                         longint e, longint f, longint g, longint h);
        sgi_pkg::t_pair p;
        p.p1x = CW'(a); p.p1y = CW'(b); p.p2x = CW'(c); p.p2y = CW'(d);
        p.q1x = CW'(e); p.q1y = CW'(f); p.q2x = CW'(g); p.q2y = CW'(h);
        send_pair(p);
    endtask

    task automatic test_directed();
        longint mx, mn;
        mx = 64'sd2147483647;
        mn = -64'sd2147483648;
        pair8(0, 0, 4*ONE, 4*ONE, 0, 4*ONE, 4*ONE, 0);
        pair8(0, 0, ONE, ONE, 3*ONE, 0, 3*ONE, 5*ONE);
        pair8(0, 0, 3*ONE, ONE, ONE, 0, ONE + 7, 5*ONE);
        pair8(0, 0, 4*ONE, 0, 0, ONE, 4*ONE, ONE);
        pair8(ONE, 2*ONE, ONE, 2*ONE, ONE, 2*ONE, ONE, 2*ONE);
        pair8(ONE, 2*ONE, ONE, 2*ONE, ONE, 3*ONE, ONE, 3*ONE);
        pair8(2*ONE, 0, 2*ONE, 0, 0, 0, 4*ONE, 0);
        pair8(5*ONE, 0, 5*ONE, 0, 0, 0, 4*ONE, 0);
        pair8(ONE, 3*ONE, ONE, 3*ONE, ONE, 0, ONE, 5*ONE);
        pair8(ONE, 0, ONE, 5*ONE, ONE, 3*ONE, ONE, 3*ONE);
        pair8(ONE, 0, ONE, 5*ONE, ONE, 7*ONE, ONE, 7*ONE);
        pair8(0, 0, 4*ONE, 0, 2*ONE, 0, 6*ONE, 0);
        pair8(0, 0, 2*ONE, 0, 2*ONE, 0, 4*ONE, 0);
        pair8(0, 0, ONE, 0, 2*ONE, 0, 3*ONE, 0);
        pair8(0, 0, 0, 4*ONE, 0, ONE, 0, 2*ONE);
        pair8(6*ONE, 3*ONE, 0, 0, ONE, ONE/2, 8*ONE, 4*ONE);
        pair8(mx, mx, mx, mx, mx, mx, mx, mx);
        pair8(mn, mn, mn, mn, mn, mn, mn, mn);
        pair8(mn, mn, mx, mx, mn, mx, mx, mn);
        pair8(mn, 0, mx, 0, mx, 0, mn, 0);
        pair8(mx, mn, mn, mx, 0, 0, 1, -1);
        pair8(mn, mx, mn, mx, mn, mn, mn, mx);
        pair8(-1, -1, 1, 1, -1, 1, 1, -1);
    endtask

    function automatic longint near();
        longint v;
        v = longint'($urandom_range(16*ONE)) - 8*ONE;
        if ($urandom_range(1)) v = (v >>> FRACTION_BITS) * ONE;
        return v;
    endfunction

    task automatic test_random();
        sgi_pkg::t_pair p;
        longint qx, qy, vx, vy, a, b, sc;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm = n >= 600 && n < 750;
            case ($urandom_range(9))
                0, 1: begin
                    p = {$urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom};
                end
                2, 3, 4: begin
                    pair8(near(), near(), near(), near(), near(), near(), near(), near());
                    continue;
                end
                5, 6, 9: begin
                    // collinear pairs along a shared line
                    sc = $urandom_range(9) == 9 ? (64'sd1 << 26) : ONE;
                    qx = $urandom_range(9) == 9 ? longint'($urandom_range(2**30)) - 2**29
                                               : near();
                    qy = near();
                    vx = (longint'($urandom_range(6)) - 3) * sc
                         / longint'($urandom_range(1) + 1);
                    vy = (longint'($urandom_range(6)) - 3) * sc
                         / longint'($urandom_range(1) + 1);
                    a = longint'($urandom_range(4)) - 1;
                    b = longint'($urandom_range(4)) - 1;
                    pair8(qx + vx*a/2, qy + vy*a/2, qx + vx*b/2, qy + vy*b/2,
                          qx, qy, qx + vx, qy + vy);
                    continue;
                end
                7: begin
                    qx = near(); qy = near();
                    a = $urandom_range(1) ? qx : near();
                    pair8(a, qy, a, qy, qx, qy - ONE, qx, qy + ONE * $urandom_range(1));
                    continue;
                end
                default: begin
                    qx = near(); qy = near();
                    pair8(qx, qy, near(), near(), qx, qy, near(), near());
                    continue;
                end
            endcase
            send_pair(p);
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
